// ----- hw/rtl/lcgr_pkg.sv -----
`default_nettype none

package lcgr_pkg;

  typedef logic [31:0] word_t;

  localparam int WORD_W = 32;
  localparam int BOUND_W = 31;

  // Multiplier and increment of the generator.
  localparam word_t LCG_MULT = 32'h5D58_8B65;
  localparam word_t LCG_INC = 32'h0000_0001;

  // Low 15 bits form the Q0.15 fraction.
  localparam word_t FRAC_MASK = 32'h0000_7FFF;
  localparam word_t ALL_ONES = 32'hFFFF_FFFF;

  localparam logic [1:0] CMD_RAW = 2'd0;
  localparam logic [1:0] CMD_FRAC = 2'd1;
  localparam logic [1:0] CMD_RANGE = 2'd2;

endpackage

`default_nettype wire

// ----- hw/rtl/lcgr_mul.sv -----
`default_nettype none

// Shift-and-add advance of the seed: one multiplier bit per cycle.
module lcgr_mul (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                start,
  input  wire lcgr_pkg::word_t     seed_in,
  output logic                     done,
  output lcgr_pkg::word_t          product
);

  logic            busy;
  logic [4:0]      cnt;
  lcgr_pkg::word_t mcand;
  lcgr_pkg::word_t acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= 5'd0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= 5'd0;
      end else if (busy) begin
        cnt <= cnt + 5'd1;
        if (cnt == 5'd31) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // The increment is folded in as the starting value of the accumulator.
  always_ff @(posedge clk) begin
    if (start) begin
      acc   <= lcgr_pkg::LCG_INC;
      mcand <= seed_in;
    end else if (busy) begin
      if (lcgr_pkg::LCG_MULT[cnt]) begin
        acc <= acc + mcand;
      end
      mcand <= {mcand[30:0], 1'b0};
    end
  end

  assign product = acc;

endmodule

`default_nettype wire

// ----- hw/rtl/lcgr_div.sv -----
`default_nettype none

// Restoring divider: one quotient bit per cycle.
module lcgr_div (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                start,
  input  wire lcgr_pkg::word_t     dividend,
  input  wire lcgr_pkg::word_t     divisor,
  output logic                     done,
  output lcgr_pkg::word_t          quotient
);

  logic            busy;
  logic [4:0]      cnt;
  lcgr_pkg::word_t rem;
  lcgr_pkg::word_t dvd;
  lcgr_pkg::word_t dsr;
  logic [32:0]     shifted;
  logic [32:0]     diff;
  logic            ge;

  always_comb begin
    shifted = {rem, dvd[31]};
    diff    = shifted - {1'b0, dsr};
    ge      = (shifted >= {1'b0, dsr});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= 5'd0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= 5'd0;
      end else if (busy) begin
        cnt <= cnt + 5'd1;
        if (cnt == 5'd31) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Dividend bits leave at the top while quotient bits enter at the bottom.
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      dvd <= dividend;
      dsr <= divisor;
    end else if (busy) begin
      rem <= ge ? diff[31:0] : shifted[31:0];
      dvd <= {dvd[30:0], ge};
    end
  end

  assign quotient = dvd;

endmodule

`default_nettype wire

// ----- hw/rtl/lcg_random_with_range.sv -----
// Raw and fraction commands make one pass through the bit-serial multiplier; a range draw
// makes one divider pass for the divisor, then a multiplier and a divider pass per advance,
// and the unused code loads its zero result without either unit.
// A new input beat is taken the cycle after a result is loaded, even if it is still stalled.
// Synchronous active-high reset sets the seed to 1 and empties the output register.
`default_nettype none

module lcg_random_with_range (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  command,
  input  wire logic [30:0] upper_bound,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [31:0]      value
);

  // Sequencer states.
  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_DIVD = 3'd1;
  localparam logic [2:0] ST_MUL  = 3'd2;
  localparam logic [2:0] ST_DIVQ = 3'd3;
  localparam logic [2:0] ST_DONE = 3'd4;

  logic [2:0]      state;
  logic [2:0]      state_next;
  logic [1:0]      cmd;
  logic [30:0]     bound;
  lcgr_pkg::word_t seed;
  lcgr_pkg::word_t d;
  lcgr_pkg::word_t result;
  lcgr_pkg::word_t result_next;

  logic            accept;
  logic            out_free;
  logic            mul_start;
  logic            mul_done;
  lcgr_pkg::word_t mul_product;
  logic            div_start;
  logic            div_done;
  lcgr_pkg::word_t div_quotient;
  lcgr_pkg::word_t div_dividend;
  lcgr_pkg::word_t div_divisor;
  lcgr_pkg::word_t span;

  // Items are worked one at a time; the input is only open while idle.
  assign in_stall = (state != ST_IDLE);
  assign accept   = in_valid && !in_stall;
  // The output register can take a result if it is empty or being emptied now.
  assign out_free = !out_valid || !out_stall;

  // n + 1 always fits in 32 bits because n is at most 2^31 - 1.
  assign span = {1'b0, upper_bound} + 32'd1;

  // The divider first forms the range divisor from the new beat, later the draw.
  assign div_dividend = (state == ST_IDLE) ? lcgr_pkg::ALL_ONES : mul_product;
  assign div_divisor  = (state == ST_IDLE) ? span : d;

  always_comb begin
    state_next  = state;
    result_next = result;
    mul_start   = 1'b0;
    div_start   = 1'b0;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          case (command)
            lcgr_pkg::CMD_RAW, lcgr_pkg::CMD_FRAC: begin
              mul_start  = 1'b1;
              state_next = ST_MUL;
            end
            lcgr_pkg::CMD_RANGE: begin
              div_start  = 1'b1;
              state_next = ST_DIVD;
            end
            default: begin
              // The unused command leaves the seed alone and returns zero.
              result_next = '0;
              state_next  = ST_DONE;
            end
          endcase
        end
      end
      ST_DIVD: begin
        if (div_done) begin
          mul_start  = 1'b1;
          state_next = ST_MUL;
        end
      end
      ST_MUL: begin
        if (mul_done) begin
          if (cmd == lcgr_pkg::CMD_RANGE) begin
            div_start  = 1'b1;
            state_next = ST_DIVQ;
          end else if (cmd == lcgr_pkg::CMD_FRAC) begin
            result_next = mul_product & lcgr_pkg::FRAC_MASK;
            state_next  = ST_DONE;
          end else begin
            result_next = mul_product;
            state_next  = ST_DONE;
          end
        end
      end
      ST_DIVQ: begin
        if (div_done) begin
          // A draw above the bound is rejected and the seed advances again.
          if (div_quotient > {1'b0, bound}) begin
            mul_start  = 1'b1;
            state_next = ST_MUL;
          end else begin
            result_next = div_quotient;
            state_next  = ST_DONE;
          end
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      seed      <= 32'd1;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_MUL && mul_done) begin
        seed <= mul_product;
      end
      if (state == ST_DONE && out_free) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    result <= result_next;
    if (accept) begin
      cmd   <= command;
      bound <= upper_bound;
    end
    // A quotient of zero cannot occur for legal bounds, but it is mapped to one.
    if (state == ST_DIVD && div_done) begin
      d <= (div_quotient == '0) ? 32'd1 : div_quotient;
    end
    if (state == ST_DONE && out_free) begin
      value <= result;
    end
  end

  lcgr_mul u_mul (
    .clk     (clk),
    .rst     (rst),
    .start   (mul_start),
    .seed_in (seed),
    .done    (mul_done),
    .product (mul_product)
  );

  lcgr_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_quotient)
  );

endmodule

`default_nettype wire

// ----- hw/rtl/lcgr_checker.sv -----
`default_nettype none

module lcgr_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_valid,
  input wire logic        in_stall,
  input wire logic [1:0]  command,
  input wire logic [30:0] upper_bound,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [31:0] value
);

  // A held result stays put until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(value))
    else $error("result changed while stalled");

  // One item at a time: the input closes right after a beat is taken.
  a_in_closes: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input open the cycle after a beat");

  // Reset empties the output register.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result present after reset");

  // A presented result is always fully defined.
  a_value_known: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !$isunknown(value))
    else $error("result has unknown bits");

  // A range draw keeps the input closed at least until its first divider pass is through.
  a_range_slow: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && (command == lcgr_pkg::CMD_RANGE) |=> ##33 in_stall)
    else $error("range draw finished too early");

endmodule

bind lcg_random_with_range lcgr_checker u_lcgr_checker (.*);

`default_nettype wire

// ----- bench/lcg_draw_checker.sv -----
`timescale 1ns / 1ps

module lcg_draw_checker (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       in_valid,
  input  wire logic                       in_stall,
  input  wire logic [1:0]                 command,
  input  wire logic [lcgr_pkg::BOUND_W-1:0] upper_bound,
  input  wire logic                       out_valid,
  input  wire logic                       out_stall,
  input  wire logic [lcgr_pkg::WORD_W-1:0]  value,
  output int                              mismatches,
  output int                              draws_pending
);

  lcgr_pkg::word_t seed_copy;
  lcgr_pkg::word_t draw_q[$];

  function automatic lcgr_pkg::word_t lcg_advance(input lcgr_pkg::word_t s);
    return s * lcgr_pkg::LCG_MULT + lcgr_pkg::LCG_INC;
  endfunction

  // Works out the value that one command beat yields and moves the seed copy along.
  function automatic lcgr_pkg::word_t predict_draw(input logic [1:0] cmd,
                                                   input logic [lcgr_pkg::BOUND_W-1:0] n);
    lcgr_pkg::word_t span;
    lcgr_pkg::word_t divisor;
    lcgr_pkg::word_t draw;
    draw = '0;
    case (cmd)
      lcgr_pkg::CMD_RAW: begin
        seed_copy = lcg_advance(seed_copy);
        draw = seed_copy;
      end
      lcgr_pkg::CMD_FRAC: begin
        seed_copy = lcg_advance(seed_copy);
        draw = seed_copy & lcgr_pkg::FRAC_MASK;
      end
      lcgr_pkg::CMD_RANGE: begin
        span = {1'b0, n} + 32'd1;
        divisor = lcgr_pkg::ALL_ONES / span;
        if (divisor == '0) begin
          divisor = 32'd1;
        end
        // Rejection loop: every refused draw costs one more advance.
        do begin
          seed_copy = lcg_advance(seed_copy);
          draw = seed_copy / divisor;
        end while (draw > {1'b0, n});
      end
      default: begin
        draw = '0;
      end
    endcase
    return draw;
  endfunction

  always @(posedge clk) begin
    lcgr_pkg::word_t wanted;
    if (rst) begin
      seed_copy = 32'd1;
      mismatches = 0;
      draw_q.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (draw_q.size() == 0) begin
          if (mismatches < 10) begin
            $display("%0t: result beat %h arrived with nothing expected", $time, value);
          end
          mismatches++;
        end else begin
          wanted = draw_q.pop_front();
          if (value !== wanted) begin
            if (mismatches < 10) begin
              $display("%0t: value mismatch, expected %h, got %h", $time, wanted, value);
            end
            mismatches++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        draw_q.push_back(predict_draw(command, upper_bound));
      end
    end
    draws_pending = draw_q.size();
  end

endmodule

// ----- bench/lcg_random_with_range_tb.sv -----
`timescale 1ns / 1ps

module lcg_random_with_range_tb;

  localparam int BOUND_W = lcgr_pkg::BOUND_W;
  localparam int WORD_W = lcgr_pkg::WORD_W;

  // The fourth command code has no meaning; the block must answer it with zero
  // and leave the seed alone.
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  // A range draw usually needs one or two advances. The limit is set so that,
  // even with stalls and gaps, it only trips on a hang.
  localparam int CYCLE_LIMIT = 1000000;
  localparam int RANDOM_BEATS = 500;
  localparam int DRAIN_CYCLES = 100;

  logic                clk;
  logic                rst;
  logic                in_valid;
  logic                in_stall;
  logic [1:0]          command;
  logic [BOUND_W-1:0]  upper_bound;
  logic                out_valid;
  logic                out_stall;
  logic [WORD_W-1:0]   value;

  int mismatches;
  int draws_pending;

  lcg_random_with_range DUT (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .command     (command),
    .upper_bound (upper_bound),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .value       (value)
  );

  // The checker mirrors the seed, predicts every accepted beat and compares the
  // results in order. The top only drives stimulus and reads its counts.
  lcg_draw_checker draw_check (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .command       (command),
    .upper_bound   (upper_bound),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .value         (value),
    .mismatches    (mismatches),
    .draws_pending (draws_pending)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Runaway guard. It counts rising edges and ends the run if the stimulus
  // never finishes.
  initial begin : watchdog
    int cycle_count;
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("RESULT: ERROR");
    $finish;
  end

  // Gap lengths: mostly none or a few cycles, now and then a long one.
  function automatic int random_gap();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 55) begin
      return 0;
    end else if (pick < 90) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(10, 40);
  endfunction

  // Bounds lean toward small values and toward values near powers of two and the
  // top of the field, where the divisor changes step. Some are random values of
  // random width, and the rest are spread over all 31 bits.
  function automatic logic [BOUND_W-1:0] random_bound();
    int pick;
    int shift;
    logic [BOUND_W-1:0] bound;
    pick = $urandom_range(0, 9);
    shift = $urandom_range(0, BOUND_W - 1);
    bound = BOUND_W'($urandom);
    case (pick)
      0, 1, 2: begin
        bound = BOUND_W'($urandom_range(0, 15));
      end
      3: begin
        bound = BOUND_W'($urandom_range(16, 1000));
      end
      4: begin
        bound = (BOUND_W'(1) << shift) + BOUND_W'($urandom_range(0, 2)) - BOUND_W'(1);
      end
      5: begin
        bound = {BOUND_W{1'b1}} - BOUND_W'($urandom_range(0, 3));
      end
      6: begin
        bound = bound >> shift;
      end
      default: begin
      end
    endcase
    return bound;
  endfunction

  // Presents one beat from a falling edge and holds it until the block takes it.
  // in_stall is read just after the rising edge, so it is the value the block
  // saw at that edge. Returns at the next falling edge.
  task automatic send_beat(input logic [1:0] cmd, input logic [BOUND_W-1:0] bound);
    in_valid = 1'b1;
    command = cmd;
    upper_bound = bound;
    do begin
      @(posedge clk);
    end while (in_stall);
    @(negedge clk);
  endtask

  // Drops valid for some cycles and puts junk on the payload, which the block
  // has to ignore while valid is low.
  task automatic hold_off(input int cycles);
    if (cycles > 0) begin
      in_valid = 1'b0;
      command = 2'($urandom);
      upper_bound = BOUND_W'($urandom);
      repeat (cycles) @(negedge clk);
    end
  endtask

  task automatic wait_for_drain();
    in_valid = 1'b0;
    while (draws_pending != 0) begin
      @(negedge clk);
    end
  endtask

  // Result side: calm stretches with no stall at all, long stalls now and then,
  // and otherwise short random flicker.
  initial begin : result_stall
    int run;
    out_stall = 1'b0;
    forever begin
      case ($urandom_range(0, 9))
        0, 1: begin
          out_stall = 1'b0;
          run = $urandom_range(20, 150);
        end
        2: begin
          out_stall = 1'b1;
          run = $urandom_range(10, 60);
        end
        default: begin
          out_stall = ($urandom_range(0, 1) == 1);
          run = $urandom_range(1, 3);
        end
      endcase
      repeat (run) @(negedge clk);
    end
  end

  initial begin : stimulus
    int sent;
    int pick;
    logic [1:0] cmd;
    rst = 1'b1;
    in_valid = 1'b0;
    command = lcgr_pkg::CMD_RAW;
    upper_bound = '0;
    repeat (10) @(negedge clk);
    rst = 1'b0;

    // Directed beats. The first raw draw after reset checks the seed start value.
    // Then the extremes of the bound: zero, one, the full 31-bit bound whose
    // span makes the divisor one, and values around the steps of the divisor.
    // The unused code comes back to back and with a full bound, and the ignored
    // bound field is driven to all ones on the other commands.
    send_beat(lcgr_pkg::CMD_RAW, '0);
    send_beat(lcgr_pkg::CMD_FRAC, '0);
    send_beat(lcgr_pkg::CMD_RANGE, '0);
    send_beat(lcgr_pkg::CMD_RANGE, BOUND_W'(1));
    send_beat(lcgr_pkg::CMD_RANGE, {BOUND_W{1'b1}});
    send_beat(lcgr_pkg::CMD_RANGE, {BOUND_W{1'b1}} - BOUND_W'(1));
    send_beat(CMD_UNUSED, {BOUND_W{1'b1}});
    send_beat(CMD_UNUSED, '0);
    send_beat(lcgr_pkg::CMD_RAW, {BOUND_W{1'b1}});
    hold_off(random_gap());
    send_beat(lcgr_pkg::CMD_FRAC, BOUND_W'(32'h5555_5555));
    send_beat(lcgr_pkg::CMD_RANGE, BOUND_W'(32'h4000_0000));
    send_beat(lcgr_pkg::CMD_RANGE, BOUND_W'(32'h3FFF_FFFF));
    send_beat(lcgr_pkg::CMD_RANGE, BOUND_W'(32'h5555_5555));
    hold_off(random_gap());
    send_beat(lcgr_pkg::CMD_RANGE, BOUND_W'(32'h2AAA_AAAA));
    send_beat(lcgr_pkg::CMD_RANGE, BOUND_W'(2));
    send_beat(lcgr_pkg::CMD_FRAC, {BOUND_W{1'b1}});
    send_beat(CMD_UNUSED, BOUND_W'(32'h2AAA_AAAA));
    send_beat(lcgr_pkg::CMD_RAW, '0);
    send_beat(lcgr_pkg::CMD_RANGE, BOUND_W'(32'h0000_FFFF));
    send_beat(lcgr_pkg::CMD_RANGE, BOUND_W'(32'h0000_7FFF));

    // Let everything come out before the random part so the sender sees a fully
    // idle block at least once.
    wait_for_drain();

    // Random part. Range draws dominate since they carry the rejection loop.
    // The unused code is sent too but does not count toward the total. The
    // first twenty beats of every hundred run with no gaps on the input side.
    sent = 0;
    while (sent < RANDOM_BEATS) begin
      pick = $urandom_range(0, 19);
      if (pick < 8) begin
        cmd = lcgr_pkg::CMD_RANGE;
      end else if (pick < 13) begin
        cmd = lcgr_pkg::CMD_RAW;
      end else if (pick < 18) begin
        cmd = lcgr_pkg::CMD_FRAC;
      end else begin
        cmd = CMD_UNUSED;
      end
      if ((sent % 100) >= 20) begin
        hold_off(random_gap());
      end
      if (sent == RANDOM_BEATS / 2) begin
        wait_for_drain();
      end
      send_beat(cmd, random_bound());
      if (cmd != CMD_UNUSED) begin
        sent++;
      end
    end

    // Wait for the last results, then a little longer in case a stray beat
    // comes out of the block.
    wait_for_drain();
    repeat (DRAIN_CYCLES) @(negedge clk);

    if (mismatches == 0 && draws_pending == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ----- files.f -----
hw/rtl/lcgr_pkg.sv
hw/rtl/lcgr_mul.sv
hw/rtl/lcgr_div.sv
hw/rtl/lcg_random_with_range.sv
hw/rtl/lcgr_checker.sv
bench/lcg_draw_checker.sv
bench/lcg_random_with_range_tb.sv
